// ===== design/periodic_timer_bank_macros.svh =====
// ----------------------------------------------------------------------------
// periodic_timer_bank assertion macros
// Clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_BANK_MACROS_SVH
`define PERIODIC_TIMER_BANK_MACROS_SVH

// condition holds at every edge out of reset
`define PTB_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define PTB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ptb_pkg.sv =====
// ----------------------------------------------------------------------------
// ptb_pkg
// Field widths, item codes and constants of the periodic timer bank.
// ----------------------------------------------------------------------------
package ptb_pkg;

    localparam int FUNC_W   = 3;
    localparam int ID_W     = 5;
    localparam int PERIOD_W = 32;
    localparam int AMOUNT_W = 16;
    localparam int MASK_W   = 16;

    // step used by a tick whose amount is zero
    localparam logic [AMOUNT_W-1:0] TICK_DEFAULT = AMOUNT_W'(10);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK    = 3'd0,
        FUNC_SET     = 3'd1,
        FUNC_KILL    = 3'd2,
        FUNC_RESTART = 3'd3,
        FUNC_POLL    = 3'd4
    } func_t;

endpackage

// ===== design/periodic_timer_bank.sv =====
// ----------------------------------------------------------------------------
// periodic_timer_bank
// Bank of NUM_TIMERS periodic timers driven by tick/set/kill/restart/poll items.
// ----------------------------------------------------------------------------
// Each item is captured in an input register and then updates
// all timers in a single pass and lands in the result register, so with
// m_ready high one item is taken per clock and its result is registered as
// it leaves the input register. A tick updates every timer at once, one
// saturating add and compare per timer; that per-timer adder sets the timing
// path. A waiting result holds the next item in the input register, and
// s_ready stays low until that result transfers.
// ----------------------------------------------------------------------------
module periodic_timer_bank #(
    parameter int NUM_TIMERS  = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ptb_pkg::FUNC_W-1:0]    s_func,
    input  logic [ptb_pkg::ID_W-1:0]      s_timer_id,
    input  logic [ptb_pkg::PERIOD_W-1:0]  s_period,
    input  logic [ptb_pkg::AMOUNT_W-1:0]  s_tick_amount,
    input  logic                          s_notify,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_ok,
    output logic [ptb_pkg::MASK_W-1:0]    m_expired_mask
);
    import ptb_pkg::*;

    `include "periodic_timer_bank_macros.svh"

    localparam logic [PERIOD_W:0] COUNT_MAX =
        (PERIOD_W+1)'((33'd1 << COUNT_WIDTH) - 33'd1);

    // input register
    logic                  in_valid_reg;
    logic [FUNC_W-1:0]     func_reg;
    logic [ID_W-1:0]       id_reg;
    logic [PERIOD_W-1:0]   period_reg;
    logic [AMOUNT_W-1:0]   amount_reg;
    logic                  notify_reg;

    // result register
    logic                  out_valid_reg;
    logic                  ok_reg;
    logic [MASK_W-1:0]     mask_reg;
    logic                  ok_next;
    logic [MASK_W-1:0]     mask_next;

    // timer state
    logic [NUM_TIMERS-1:0]  enabled_reg,   enabled_next;
    logic [NUM_TIMERS-1:0]  notify_on_reg, notify_on_next;
    logic [NUM_TIMERS-1:0]  expired_reg,   expired_next;
    logic [COUNT_WIDTH-1:0] elapsed_reg [NUM_TIMERS];
    logic [COUNT_WIDTH-1:0] elapsed_next [NUM_TIMERS];
    logic [PERIOD_W-1:0]    limit_reg [NUM_TIMERS];
    logic [PERIOD_W-1:0]    limit_next [NUM_TIMERS];

    // per-timer tick datapath
    logic [AMOUNT_W-1:0]   step;
    logic [PERIOD_W:0]     sum_w [NUM_TIMERS];
    logic [PERIOD_W:0]     sat_w [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] running;
    logic [NUM_TIMERS-1:0] reach;
    logic [NUM_TIMERS-1:0] fire;
    logic [NUM_TIMERS-1:0] sel;
    logic [NUM_TIMERS-1:0] limit_nz;
    logic [NUM_TIMERS-1:0] elapsed_nz;
    logic                  hit_valid;
    logic                  hit_enabled;
    logic                  hit_expired;
    logic                  advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign m_valid        = out_valid_reg;
    assign m_ok           = ok_reg;
    assign m_expired_mask = mask_reg;

    assign step = (amount_reg == '0) ? TICK_DEFAULT : amount_reg;

    always_comb begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
            sel[i]        = (id_reg == ID_W'(i + 1));
            limit_nz[i]   = (limit_reg[i] != '0);
            elapsed_nz[i] = (elapsed_reg[i] != '0);
            running[i]    = enabled_reg[i] && limit_nz[i];
            sum_w[i]      = (PERIOD_W+1)'(elapsed_reg[i]) + (PERIOD_W+1)'(step);
            sat_w[i]      = (sum_w[i] > COUNT_MAX) ? COUNT_MAX : sum_w[i];
            reach[i]      = (sat_w[i][PERIOD_W-1:0] >= limit_reg[i]);
            fire[i]       = running[i] && reach[i] && notify_on_reg[i];
        end
    end

    assign hit_valid   = |sel;
    assign hit_enabled = |(sel & enabled_reg);
    assign hit_expired = |(sel & enabled_reg & expired_reg);

    // only the first sixteen timers have a mask bit
    logic [MASK_W-1:0] fire_mask;
    generate
        if (NUM_TIMERS >= MASK_W) begin : g_mask_wide
            assign fire_mask = fire[MASK_W-1:0];
        end else begin : g_mask_narrow
            assign fire_mask = MASK_W'(fire);
        end
    endgenerate

    always_comb begin
        enabled_next   = enabled_reg;
        notify_on_next = notify_on_reg;
        expired_next   = expired_reg;
        elapsed_next   = elapsed_reg;
        limit_next     = limit_reg;
        ok_next        = 1'b0;
        mask_next      = '0;

        case (func_t'(func_reg))
            FUNC_TICK: begin
                mask_next = fire_mask;
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (running[i]) begin
                        if (reach[i]) begin
                            expired_next[i] = 1'b1;
                            elapsed_next[i] = '0;
                        end else begin
                            elapsed_next[i] = sat_w[i][COUNT_WIDTH-1:0];
                        end
                    end
                end
            end
            FUNC_SET: begin
                if (hit_valid && period_reg != '0) begin
                    ok_next = 1'b1;
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (sel[i]) begin
                            enabled_next[i]   = 1'b1;
                            notify_on_next[i] = notify_reg;
                            limit_next[i]     = period_reg;
                        end
                    end
                end
            end
            FUNC_KILL: begin
                ok_next = hit_enabled;
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (sel[i]) begin
                        enabled_next[i]   = 1'b0;
                        notify_on_next[i] = 1'b0;
                        expired_next[i]   = 1'b0;
                        elapsed_next[i]   = '0;
                        limit_next[i]     = '0;
                    end
                end
            end
            FUNC_RESTART: begin
                ok_next = hit_enabled;
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (sel[i] && enabled_reg[i]) begin
                        elapsed_next[i] = '0;
                    end
                end
            end
            FUNC_POLL: begin
                ok_next = hit_expired;
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (sel[i] && enabled_reg[i]) begin
                        expired_next[i] = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg   <= s_func;
            id_reg     <= s_timer_id;
            period_reg <= s_period;
            amount_reg <= s_tick_amount;
            notify_reg <= s_notify;
        end
        if (advance) begin
            ok_reg   <= ok_next;
            mask_reg <= mask_next;
        end
    end

    // timer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg   <= '0;
            notify_on_reg <= '0;
            expired_reg   <= '0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                elapsed_reg[i] <= '0;
                limit_reg[i]   <= '0;
            end
        end else if (advance) begin
            enabled_reg   <= enabled_next;
            notify_on_reg <= notify_on_next;
            expired_reg   <= expired_next;
            elapsed_reg   <= elapsed_next;
            limit_reg     <= limit_next;
        end
    end

    // an enabled timer always has a nonzero period
    `PTB_ASSERT_ALWAYS(a_enabled_has_limit, ~|(enabled_reg & ~limit_nz), "enabled timer with zero limit")
    // a disabled timer keeps no count and no pending expiry
    `PTB_ASSERT_ALWAYS(a_idle_timer_clear, ~|(~enabled_reg & (expired_reg | elapsed_nz)), "disabled timer holds state")
    // ok and mask are never both set in one result
    `PTB_ASSERT_ALWAYS(a_ok_mask_exclusive, !(out_valid_reg && ok_reg) || mask_reg == '0, "ok with nonzero mask")
    // a processed item always produces a result
    `PTB_ASSERT_NEXT(a_advance_result, advance, out_valid_reg, "processed item produced no result")
    // a held item is not dropped
    `PTB_ASSERT_NEXT(a_hold_item, in_valid_reg && !advance, in_valid_reg, "stalled item lost")

endmodule
